/* src/ncd_pkg.sv */
// shared constants and types for the negative cycle detector
// no dependencies
package ncd_pkg;
  localparam int NODES       = 2048;
  localparam int EDGES       = 16384;
  localparam int WEIGHT_BITS = 16;
  localparam int NODE_W      = $clog2(NODES);
  localparam int EDGE_W      = $clog2(EDGES);
  localparam int DIST_W      = 32;
  localparam int HOP_W       = NODE_W + 1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef struct packed {
    logic [NODE_W-1:0]      src;
    logic [NODE_W-1:0]      dst;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   store;
    logic                   last;
  } ncd_cmd_t;
endpackage

/* src/ncd_ram.sv */
// generic single port-write, single port-read ram with registered read
// no dependencies
module ncd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/ncd_front.sv */
// front end: accepts edge transactions, unpacks them into commands and pushes those to a queue
// depends on ncd_pkg
module ncd_front import ncd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,
  input  logic              in_tlast,
  output ncd_cmd_t          cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);
  ncd_cmd_t q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0] cnt_r;
  logic push, pop;
  ncd_cmd_t c;

  always_comb begin
    c.src    = in_tdata[NODE_W-1:0];
    c.dst    = in_tdata[2*NODE_W-1:NODE_W];
    c.weight = in_tdata[2*NODE_W+WEIGHT_BITS-1:2*NODE_W];
    c.store  = 1'b1;
    c.last   = in_tlast;
  end

  assign in_tready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign push = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
    if (push) q_r[wp_r] <= c;
  end
endmodule

/* src/ncd_back.sv */
// back end: edge store, spfa search sequencer, table clearing and result register
// depends on ncd_pkg and ncd_ram
module ncd_back import ncd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ncd_cmd_t          cmd,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [NODE_W-1:0] node_count,
  output logic              res_valid,
  output logic [1:0]        res_data,
  input  logic              res_ready
);
  typedef enum logic [3:0] {
    S_CLEAR, S_LOAD, S_INIT, S_POP, S_POPW, S_EDGE, S_EDGEW, S_DJ, S_RELAX, S_DONE
  } state_t;
  state_t st_r;

  logic [EDGE_W:0]   es_r;
  logic              ovf_r, neg_r, rv_r, hr_r, lv_r;
  logic [NODE_W-1:0] n_r, t_r, j_r, ic_r, clr_r;
  logic [NODE_W-1:0] qrd_r, qwr_r;
  logic [NODE_W:0]   used_r;
  logic [EDGE_W-1:0] e_r;
  logic signed [DIST_W-1:0] dt_r, cand_r;
  logic [HOP_W-1:0]  ht_r;

  // ram ports; head entries carry a valid bit on top
  logic              hd_we;  logic [NODE_W-1:0] hd_wa, hd_ra; logic [EDGE_W:0] hd_wd, hd_rd;
  logic              ed_we;  logic [EDGE_W-1:0] ed_wa, ed_ra;
  logic [NODE_W+WEIGHT_BITS+EDGE_W:0] ed_wd, ed_rd;
  logic              ds_we;  logic [NODE_W-1:0] ds_wa, ds_ra;
  logic [DIST_W+HOP_W-1:0] ds_wd, ds_rd;
  logic              wf_we;  logic [NODE_W-1:0] wf_wa, wf_ra, wf_wd, wf_rd;
  logic              qf_we;  logic [NODE_W-1:0] qf_wa, qf_ra; logic qf_wd, qf_rd;

  ncd_ram #(.WIDTH(EDGE_W+1), .DEPTH(NODES)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  ncd_ram #(.WIDTH(NODE_W+WEIGHT_BITS+EDGE_W+1), .DEPTH(EDGES)) u_edge (
    .clk, .we(ed_we), .waddr(ed_wa), .wdata(ed_wd), .raddr(ed_ra), .rdata(ed_rd));
  ncd_ram #(.WIDTH(DIST_W+HOP_W), .DEPTH(NODES)) u_dist (
    .clk, .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(ds_ra), .rdata(ds_rd));
  ncd_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fifo (
    .clk, .we(wf_we), .waddr(wf_wa), .wdata(wf_wd), .raddr(wf_ra), .rdata(wf_rd));
  ncd_ram #(.WIDTH(1), .DEPTH(NODES)) u_qflag (
    .clk, .we(qf_we), .waddr(qf_wa), .wdata(qf_wd), .raddr(qf_ra), .rdata(qf_rd));

  logic store_ok;
  assign store_ok = cmd.store && !es_r[EDGE_W];
  // a command is taken once its head entry has been read
  assign cmd_ready = (st_r == S_LOAD) && hr_r;

  // edge fields of a stored edge record
  logic [NODE_W-1:0]        ed_tgt;
  logic signed [WEIGHT_BITS-1:0] ed_w;
  logic [EDGE_W-1:0]        ed_lnk;
  logic                     ed_lv;
  assign {ed_lv, ed_lnk, ed_w, ed_tgt} = ed_rd;

  logic signed [DIST_W-1:0] dj;
  logic [HOP_W-1:0] hnew;
  logic improve, hit, enq;
  assign dj = ds_rd[DIST_W-1:0];
  assign hnew = ht_r + HOP_W'(1);
  assign improve = (dj > cand_r);
  assign hit = (hnew > {1'b0, n_r});
  assign enq = improve && !hit && !qf_rd && (used_r != (NODE_W+1)'(NODES));

  always_comb begin
    hd_we = 1'b0; hd_wa = cmd.src; hd_wd = {1'b1, es_r[EDGE_W-1:0]}; hd_ra = cmd.src;
    ed_we = 1'b0; ed_wa = es_r[EDGE_W-1:0];
    ed_wd = {hd_rd, cmd.weight, cmd.dst};
    ed_ra = e_r;
    ds_we = 1'b0; ds_wa = j_r; ds_wd = {hnew, cand_r}; ds_ra = ed_tgt;
    wf_we = 1'b0; wf_wa = qwr_r; wf_wd = ic_r; wf_ra = qrd_r;
    qf_we = 1'b0; qf_wa = j_r; qf_wd = 1'b1; qf_ra = ed_tgt;
    unique case (st_r)
      S_LOAD: begin
        if (cmd_valid && hr_r && store_ok) begin
          hd_we = 1'b1; ed_we = 1'b1;
        end
      end
      S_INIT: begin
        wf_we = 1'b1; qf_we = 1'b1; qf_wa = ic_r;
      end
      S_POPW: begin
        // head and own distance of the popped node are read here
        hd_ra = wf_rd; ds_ra = wf_rd;
        qf_we = 1'b1; qf_wa = wf_rd; qf_wd = 1'b0;
      end
      S_RELAX: begin
        ds_we = improve;
        wf_wd = j_r;
        wf_we = enq;
        qf_we = enq;
      end
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_r; hd_wd = '0;
        ds_we = 1'b1; ds_wa = clr_r; ds_wd = '0;
        qf_we = 1'b1; qf_wa = clr_r; qf_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; es_r <= '0;
      ovf_r <= 1'b0; rv_r <= 1'b0; hr_r <= 1'b0;
      used_r <= '0; qrd_r <= '0; qwr_r <= '0;
    end else begin
      if (rv_r && res_ready) rv_r <= 1'b0;
      unique case (st_r)
        S_LOAD: begin
          if (cmd_valid) begin
            if (!hr_r) begin
              hr_r <= 1'b1;
            end else begin
              hr_r <= 1'b0;
              if (cmd.store) begin
                if (!es_r[EDGE_W]) es_r <= es_r + (EDGE_W+1)'(1);
                else ovf_r <= 1'b1;
              end
              if (cmd.last) begin
                n_r <= (node_count > NODE_W'(NODES-1)) ? NODE_W'(NODES-1) : node_count;
                ic_r <= '0; qwr_r <= '0; qrd_r <= '0; used_r <= '0;
                st_r <= S_INIT;
              end
            end
          end
        end
        S_INIT: begin
          qwr_r <= qwr_r + NODE_W'(1);
          used_r <= used_r + (NODE_W+1)'(1);
          ic_r <= ic_r + NODE_W'(1);
          if (ic_r == n_r) st_r <= S_POP;
        end
        S_POP: begin
          if (used_r == '0) begin
            neg_r <= 1'b0; st_r <= S_DONE;
          end else st_r <= S_POPW;
        end
        S_POPW: begin
          t_r <= wf_rd;
          qrd_r <= qrd_r + NODE_W'(1);
          used_r <= used_r - (NODE_W+1)'(1);
          st_r <= S_EDGE;
        end
        S_EDGE: begin
          e_r <= hd_rd[EDGE_W-1:0];
          dt_r <= ds_rd[DIST_W-1:0];
          ht_r <= ds_rd[DIST_W+HOP_W-1:DIST_W];
          st_r <= hd_rd[EDGE_W] ? S_EDGEW : S_POP;
        end
        S_EDGEW: st_r <= S_DJ;  // first edge record read in flight
        S_DJ: begin
          j_r <= ed_tgt;
          cand_r <= dt_r + DIST_W'(ed_w);
          lv_r <= ed_lv;
          e_r <= ed_lnk;
          st_r <= S_RELAX;
        end
        S_RELAX: begin
          // a self loop also moves the popped node's own distance
          if (improve && j_r == t_r) begin
            dt_r <= cand_r; ht_r <= hnew;
          end
          if (enq) begin
            qwr_r <= qwr_r + NODE_W'(1);
            used_r <= used_r + (NODE_W+1)'(1);
          end
          if (improve && hit) begin
            neg_r <= 1'b1; st_r <= S_DONE;
          end else if (lv_r) st_r <= S_DJ;
          else st_r <= S_POP;
        end
        S_DONE: begin
          if (!rv_r) begin
            rv_r <= 1'b1;
            res_data <= {ovf_r, neg_r};
            clr_r <= '0;
            st_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + NODE_W'(1);
          if (clr_r == NODE_W'(NODES-1)) begin
            es_r <= '0; ovf_r <= 1'b0; hr_r <= 1'b0;
            st_r <= S_LOAD;
          end
        end
        default: st_r <= S_CLEAR;
      endcase
    end
  end

  assign res_valid = rv_r;
endmodule

/* src/negative_cycle_detect.sv */
// top level of the negative cycle detector: front queue, back end, config register
// depends on ncd_pkg, ncd_front, ncd_back
// store path: an edge waits in the front queue, then an idle back end reads the head
//   entry of its source and writes the edge record and new head; it takes edges one at
//   a time and none during a search or sweep. After the last edge the search queues
//   nodes 0 to node_count, pops each and relaxes its edges, then registers the result
// reset: synchronous active low rst_n; node_count goes to 1; the head, distance and queued
//   flag rams are swept clear, all 2048 entries, after reset and after every result
module negative_cycle_detect import ncd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // src_node[10:0], dst_node[21:11], edge_weight[37:22]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // has_negative_cycle[0], edge_overflow[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  ncd_cmd_t cmd;
  logic cmd_valid, cmd_ready;
  logic [NODE_W-1:0] nc_r;
  logic [1:0] res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) nc_r <= NODE_W'(1);
    else if (cfg_valid) nc_r <= cfg_data;
  end

  ncd_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .cmd, .cmd_valid, .cmd_ready);
  ncd_back u_back (.clk, .rst_n, .cmd, .cmd_valid, .cmd_ready, .node_count(nc_r),
    .res_valid(out_tvalid), .res_data(res), .res_ready(out_tready));

  assign out_tdata = {6'b0, res};
endmodule

/* src/ncd_checker.sv */
// port-level checks for the negative cycle detector, bound to the top level
// depends on negative_cycle_detect
module ncd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata)) else $error("in hold");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b0) else $error("pad bits");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid) else $error("result repeated");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("reset");
endmodule

bind negative_cycle_detect ncd_checker u_ncd_checker (.*);

/* sim/tb_negative_cycle_detect.sv */
// self-checking testbench for negative_cycle_detect: streams edge graphs,
// predicts each verdict with its own queue-based relaxation search
// depends on ncd_pkg and the negative_cycle_detect rtl
module tb_negative_cycle_detect;
  import ncd_pkg::*;

  typedef struct {
    bit [10:0] src;
    bit [10:0] dst;
    bit [15:0] weight;
    bit        last;
  } edge_item_t;

  typedef struct {
    bit neg_cycle;
    bit overflow;
  } verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;

  negative_cycle_detect dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  bit [14:0]   list_head [NODES];
  bit          head_ok   [NODES];
  bit [10:0]   edge_dst  [EDGES];
  longint      edge_cost [EDGES];
  bit [14:0]   edge_next [EDGES];
  bit          next_ok   [EDGES];
  int          edge_total;
  bit          dropped;
  longint      node_dist [NODES];
  int          hops      [NODES];
  bit          in_queue  [NODES];
  int          work_q    [NODES];
  bit [10:0]   node_limit;

  edge_item_t  pending_edges[$];
  edge_item_t  bus_edge;
  verdict_t    verdicts_due[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          failed;

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_graph();
    for (int i = 0; i < NODES; i++) begin
      head_ok[i] = 1'b0;
      node_dist[i] = 0;
      hops[i] = 0;
      in_queue[i] = 1'b0;
    end
    edge_total = 0;
    dropped = 1'b0;
  endfunction

  function automatic bit find_neg_cycle();
    int n;
    int rd;
    int wr;
    int used;
    int t;
    int e;
    int j;
    longint cand;
    n = int'(node_limit);
    rd = 0;
    wr = 0;
    used = 0;
    for (int i = 0; i <= n; i++) begin
      work_q[wr] = i;
      wr = (wr + 1) % NODES;
      used++;
      in_queue[i] = 1'b1;
    end
    while (used > 0) begin
      t = work_q[rd];
      rd = (rd + 1) % NODES;
      used--;
      in_queue[t] = 1'b0;
      if (head_ok[t]) begin
        e = int'(list_head[t]);
        forever begin
          j = int'(edge_dst[e]);
          cand = node_dist[t] + edge_cost[e];
          if (node_dist[j] > cand) begin
            node_dist[j] = cand;
            hops[j] = hops[t] + 1;
            if (hops[j] > n) return 1'b1;
            if (!in_queue[j] && used < NODES) begin
              work_q[wr] = j;
              wr = (wr + 1) % NODES;
              used++;
              in_queue[j] = 1'b1;
            end
          end
          if (!next_ok[e]) break;
          e = int'(edge_next[e]);
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void take_edge(edge_item_t it);
    verdict_t v;
    if (edge_total < EDGES) begin
      edge_dst[edge_total]  = it.dst;
      edge_cost[edge_total] = longint'($signed(it.weight));
      edge_next[edge_total] = list_head[it.src];
      next_ok[edge_total]   = head_ok[it.src];
      list_head[it.src]     = 15'(edge_total);
      head_ok[it.src]       = 1'b1;
      edge_total++;
    end else begin
      dropped = 1'b1;
    end
    if (it.last) begin
      v.neg_cycle = find_neg_cycle();
      v.overflow  = dropped;
      verdicts_due.push_back(v);
      clear_graph();
    end
  endfunction

  // edge driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) take_edge(bus_edge);
      if (!in_tvalid || in_tready) begin
        if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_edge = pending_edges.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, bus_edge.weight, bus_edge.dst, bus_edge.src};
          in_tlast  <= bus_edge.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, actual %b", $time, out_tdata[1:0]);
          failed = 1'b1;
        end else begin
          v = verdicts_due.pop_front();
          if (out_tdata[0] !== v.neg_cycle) begin
            $display("%0t: has_negative_cycle expected %b actual %b",
                     $time, v.neg_cycle, out_tdata[0]);
            failed = 1'b1;
          end
          if (out_tdata[1] !== v.overflow) begin
            $display("%0t: edge_overflow expected %b actual %b",
                     $time, v.overflow, out_tdata[1]);
            failed = 1'b1;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void add_edge(int s, int d, int w, bit lst);
    edge_item_t it;
    it.src = 11'(s);
    it.dst = 11'(d);
    it.weight = 16'(w);
    it.last = lst;
    pending_edges.push_back(it);
  endfunction

  // random graph, mostly around the active node range; returns the count of its random edges
  function automatic int add_random_graph();
    int len;
    int span;
    int a;
    int b;
    int w;
    int kind;
    len = $urandom_range(1, 12);
    span = node_limit + $urandom_range(0, 3);
    if (span > 2047) span = 2047;
    kind = $urandom_range(99);
    if (kind < 15) begin
      // plant a negative two-node loop
      a = $urandom_range(0, span);
      b = $urandom_range(0, span);
      add_edge(a, b, -3, 1'b0);
      add_edge(b, a, 1, 1'b0);
    end else if (kind < 22 && node_limit < 40) begin
      // long negative chain through nodes above the active range
      for (int i = 0; i <= node_limit + 1; i++)
        add_edge(i == 0 ? 1 : node_limit + i, node_limit + i + 1, -1, 1'b0);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) begin
        a = $urandom_range(0, 2047);
        b = $urandom_range(0, 2047);
      end else begin
        a = $urandom_range(0, span);
        b = $urandom_range(0, span);
      end
      if ($urandom_range(99) < 10) w = $urandom_range(0, 65535);
      else w = $urandom_range(0, 25) - 5;
      add_edge(a, b, w, i == len - 1);
    end
    return len;
  endfunction

  task automatic wait_idle();
    while (pending_edges.size() > 0 || in_tvalid || verdicts_due.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_node_count(int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 11'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    node_limit = 11'(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int item_goal);
    int n;
    n = 0;
    while (n < item_goal) n += add_random_graph();
    wait_idle();
  endtask

  initial begin
    int settings[6];
    failed = 1'b0;
    node_limit = 1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    clear_graph();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: self loops, weight extremes, node extremes, node zero
    add_edge(1, 1, -1, 1'b1);
    add_edge(1, 1, 0, 1'b1);
    add_edge(0, 1, 16'h8000, 1'b0);
    add_edge(1, 0, 16'h7fff, 1'b1);
    add_edge(0, 1, -5, 1'b0);
    add_edge(1, 0, 4, 1'b1);
    add_edge(2047, 2047, 16'h8000, 1'b0);
    add_edge(1, 2047, -1, 1'b0);
    add_edge(2047, 1, 0, 1'b1);
    add_edge(1, 2, -1, 1'b0);
    add_edge(2, 3, -1, 1'b1);
    add_edge(0, 0, 16'hffff, 1'b1);
    wait_idle();
    write_node_count(0);
    add_edge(0, 5, -1, 1'b1);
    add_edge(5, 6, 3, 1'b1);
    wait_idle();
    write_node_count(2047);
    add_edge(2047, 1024, -2, 1'b0);
    add_edge(1024, 2047, 1, 1'b1);
    add_edge(1365, 682, -7, 1'b1);
    wait_idle();

    settings = '{1, 0, 5, 2047, 17, 3};
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_node_count(p == 3 ? 2047 : $urandom_range(2, 40));
      run_random(p == 3 ? 120 : 320);
      write_node_count(settings[p]);
      run_random(p == 3 ? 60 : 20);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_node_count(3);
    add_edge(1, 2, -1, 1'b1);
    wait_idle();
    repeat (50) @(posedge clk);
    if (!failed) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

/* negative_cycle_detect.f */
src/ncd_pkg.sv
src/ncd_ram.sv
src/ncd_front.sv
src/ncd_back.sv
src/negative_cycle_detect.sv
src/ncd_checker.sv
sim/tb_negative_cycle_detect.sv
